@@ hdl/oled_pixel_plot_writer_top_defines.svh @@
// Assertion macros for the pixel plot writer.
// Included by the top level; no other dependencies.
`ifndef OLED_PIXEL_PLOT_WRITER_TOP_DEFINES_SVH
`define OLED_PIXEL_PLOT_WRITER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define OPPW_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define OPPW_ASSERT_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);
`define OPPW_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define OPPW_ASSERT_ALWAYS(name, expr, msg)
`define OPPW_ASSERT_IMPL(name, pre, post, msg)
`define OPPW_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

@@ hdl/oppw_pkg.sv @@
// Shared types, codes and helpers for the pixel plot writer.
// No dependencies.
package oppw_pkg;

    localparam int PAGE_W = 4;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_FLIP  = 2'd2;
    localparam logic [1:0] KIND_KEEP  = 2'd3;

    localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;

    localparam logic [2:0] BEAT_COL_CMD   = 3'd0;
    localparam logic [2:0] BEAT_COL_START = 3'd1;
    localparam logic [2:0] BEAT_COL_END   = 3'd2;
    localparam logic [2:0] BEAT_PAGE_CMD  = 3'd3;
    localparam logic [2:0] BEAT_PAGE_START = 3'd4;
    localparam logic [2:0] BEAT_PAGE_END  = 3'd5;
    localparam logic [2:0] BEAT_DATA      = 3'd6;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_BEATS = 3'b100
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // Bus pins are wired in reverse bit order.
    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

@@ hdl/oppw_store.sv @@
// Frame store: one write port, one registered read port.
// Uses oppw_pkg for the port control struct.
module oppw_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic               aclk,
    input  oppw_pkg::mem_ctl_t ctl,
    input  logic [ADDR_W-1:0]  rd_addr,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [7:0]         wr_data,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/oppw_ctrl.sv @@
// Sequencer: clearing sweep, read-modify-write of the pixel byte, bus beat emission.
// Uses oppw_pkg; drives the oppw_store ports.
module oppw_ctrl #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8,
    parameter int DEPTH   = 1024,
    parameter int ADDR_W  = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_pix_x,
    input  logic [6:0]         s_pix_y,
    input  logic [1:0]         s_kind,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_bus_byte,
    output logic               m_is_data,
    output logic               m_write_valid,
    output logic               m_status,
    output logic               m_last,
    output oppw_pkg::mem_ctl_t mem_ctl,
    output logic [ADDR_W-1:0]  mem_rd_addr,
    output logic [ADDR_W-1:0]  mem_wr_addr,
    output logic [7:0]         mem_wr_data,
    input  logic [7:0]         mem_rd_data
);

    localparam logic [7:0] COL_END_BYTE  = 8'(COLUMNS - 1);
    localparam logic [7:0] PAGE_END_BYTE = 8'(PAGES - 1);

    oppw_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [2:0]        beat_reg, beat_next;
    logic              mod_pend_reg, mod_pend_next;
    logic              m_valid_reg, m_valid_next;

    logic [7:0]                  x_reg;
    logic [oppw_pkg::PAGE_W-1:0] page_reg;
    logic [2:0]                  bit_reg;
    logic [1:0]                  kind_reg;
    logic [ADDR_W-1:0]           wr_addr_reg;
    logic [7:0]                  byte_reg;
    logic [7:0]                  bus_reg, bus_next;
    logic                        is_data_reg, is_data_next;
    logic                        wv_reg, wv_next;
    logic                        status_reg, status_next;
    logic                        last_reg, last_next;

    logic                        accept;
    logic                        out_free;
    logic                        in_range;
    logic [oppw_pkg::PAGE_W-1:0] s_page;
    logic [ADDR_W-1:0]           s_idx;
    logic [7:0]                  bit_mask;
    logic [7:0]                  mod_byte;
    logic [7:0]                  beat_byte;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == oppw_pkg::ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign in_range = ({1'b0, s_pix_x} < 9'(COLUMNS)) && ({1'b0, s_pix_y} < 8'(PAGES * 8));
    assign s_page   = s_pix_y[6:3];
    assign s_idx    = ADDR_W'(int'(s_page) * COLUMNS + int'(s_pix_x));

    // Modify the byte returned by the read issued on the accept beat.
    assign bit_mask = 8'b1 << bit_reg;
    always_comb begin
        case (kind_reg)
            oppw_pkg::KIND_SET:   mod_byte = mem_rd_data | bit_mask;
            oppw_pkg::KIND_CLEAR: mod_byte = mem_rd_data & ~bit_mask;
            oppw_pkg::KIND_FLIP:  mod_byte = mem_rd_data ^ bit_mask;
            default:              mod_byte = mem_rd_data;
        endcase
    end

    assign mem_ctl.rd_en = accept && in_range;
    assign mem_ctl.wr_en = (state_reg == oppw_pkg::ST_CLEAR) || mod_pend_reg;
    assign mem_rd_addr   = s_idx;
    assign mem_wr_addr   = (state_reg == oppw_pkg::ST_CLEAR) ? clr_addr_reg : wr_addr_reg;
    assign mem_wr_data   = (state_reg == oppw_pkg::ST_CLEAR) ? 8'h00 : mod_byte;

    always_comb begin
        case (beat_reg)
            oppw_pkg::BEAT_COL_CMD:    beat_byte = oppw_pkg::CMD_COL_ADDR;
            oppw_pkg::BEAT_COL_START:  beat_byte = x_reg;
            oppw_pkg::BEAT_COL_END:    beat_byte = COL_END_BYTE;
            oppw_pkg::BEAT_PAGE_CMD:   beat_byte = oppw_pkg::CMD_PAGE_ADDR;
            oppw_pkg::BEAT_PAGE_START: beat_byte = 8'(page_reg);
            oppw_pkg::BEAT_PAGE_END:   beat_byte = PAGE_END_BYTE;
            oppw_pkg::BEAT_DATA:       beat_byte = byte_reg;
            default:                   beat_byte = 8'h00;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        beat_next     = beat_reg;
        mod_pend_next = accept && in_range;
        m_valid_next  = m_valid_reg && !m_ready;
        bus_next      = bus_reg;
        is_data_next  = is_data_reg;
        wv_next       = wv_reg;
        status_next   = status_reg;
        last_next     = last_reg;

        case (state_reg)
            oppw_pkg::ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = oppw_pkg::ST_IDLE;
                end
            end
            oppw_pkg::ST_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    if (in_range) begin
                        bus_next    = oppw_pkg::rev8(oppw_pkg::CMD_COL_ADDR);
                        wv_next     = 1'b1;
                        status_next = 1'b0;
                        beat_next   = oppw_pkg::BEAT_COL_START;
                        state_next  = oppw_pkg::ST_BEATS;
                    end else begin
                        bus_next    = 8'h00;
                        wv_next     = 1'b0;
                        status_next = 1'b1;
                    end
                    is_data_next = 1'b0;
                    last_next    = !in_range;
                end
            end
            oppw_pkg::ST_BEATS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    bus_next     = oppw_pkg::rev8(beat_byte);
                    wv_next      = 1'b1;
                    status_next  = 1'b0;
                    is_data_next = (beat_reg == oppw_pkg::BEAT_DATA);
                    last_next    = (beat_reg == oppw_pkg::BEAT_DATA);
                    beat_next    = beat_reg + 1'b1;
                    if (beat_reg == oppw_pkg::BEAT_DATA) begin
                        state_next = oppw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = oppw_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= oppw_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            beat_reg     <= oppw_pkg::BEAT_COL_CMD;
            mod_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            beat_reg     <= beat_next;
            mod_pend_reg <= mod_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg       <= s_pix_x;
            page_reg    <= s_page;
            bit_reg     <= s_pix_y[2:0];
            kind_reg    <= s_kind;
            wr_addr_reg <= s_idx;
        end
        if (mod_pend_reg) begin
            byte_reg <= mod_byte;
        end
        bus_reg     <= bus_next;
        is_data_reg <= is_data_next;
        wv_reg      <= wv_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_bus_byte    = bus_reg;
    assign m_is_data     = is_data_reg;
    assign m_write_valid = wv_reg;
    assign m_status      = status_reg;
    assign m_last        = last_reg;

endmodule

@@ hdl/oled_pixel_plot_writer_top.sv @@
// Pixel plot writer for a page-organised monochrome display: top level.
// Depends on oppw_pkg, oppw_ctrl, oppw_store and the assertion macro header.
//
// Input channel (s_): one pixel request per beat: column, row and operation
// (set, clear, invert, keep). Result channel (m_): bus beats, bit-reversed.
// An in-range request yields seven beats: column-address command, column,
// last column, page-address command, page, last page, then the updated byte
// as data with m_last high. An out-of-range request yields one status beat
// (m_status high, m_write_valid low, m_last high) and leaves the store as is.
// The first beat is presented in the cycle after acceptance. Beats leave
// through the single output register, one per cycle while m_ready stays
// high. The byte is read from the frame memory on the accept cycle and
// written back the cycle after. After reset a clearing sweep zeroes all
// PAGES*COLUMNS entries of the store (1024 at the defaults), one entry per
// cycle, with s_ready held low. When the receiver stalls, the current beat
// holds and no new request is taken until the last beat of the current
// one is taken.
`include "oled_pixel_plot_writer_top_defines.svh"

module oled_pixel_plot_writer_top #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_pix_x,
    input  logic [6:0] s_pix_y,
    input  logic [1:0] s_kind,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_bus_byte,
    output logic       m_is_data,
    output logic       m_write_valid,
    output logic       m_status,
    output logic       m_last
);

    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    oppw_pkg::mem_ctl_t mem_ctl;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [7:0]         mem_wr_data;
    logic [7:0]         mem_rd_data;

    oppw_ctrl #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES),
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pix_x       (s_pix_x),
        .s_pix_y       (s_pix_y),
        .s_kind        (s_kind),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bus_byte    (m_bus_byte),
        .m_is_data     (m_is_data),
        .m_write_valid (m_write_valid),
        .m_status      (m_status),
        .m_last        (m_last),
        .mem_ctl       (mem_ctl),
        .mem_rd_addr   (mem_rd_addr),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_data   (mem_rd_data)
    );

    oppw_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    `OPPW_ASSERT_IMPL(a_ready_needs_free_out, s_ready, !m_valid || m_ready, "request taken while a beat is stalled")
    `OPPW_ASSERT_IMPL(a_status_beat_alone, m_valid && m_status, m_last && !m_write_valid && !m_is_data, "status beat malformed")
    `OPPW_ASSERT_NEXT(a_rmw_follows_read, mem_ctl.rd_en, mem_ctl.wr_en && !s_ready, "read not followed by write-back")
    `OPPW_ASSERT_ALWAYS(a_no_read_write_clash, !(mem_ctl.rd_en && mem_ctl.wr_en), "frame memory read and write in one cycle")

endmodule
